/* src/pcms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pcms_pkg;

    localparam int HISTORY_DEPTH = 5;
    localparam int POS_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int DUTY_MAX      = 100;
    localparam int TOTAL_W       = $clog2(DUTY_MAX * HISTORY_DEPTH + 1);
    localparam int DIV_L         = $clog2(HISTORY_DEPTH);
    // Reciprocal for an exact truncating divide by HISTORY_DEPTH over TOTAL_W bits.
    localparam int DIV_M         = (1 << (TOTAL_W + DIV_L)) / HISTORY_DEPTH + 1;
    localparam int PERIOD_BASE   = 2;

    localparam int FREQ_W  = 20;
    localparam int DUTY_W  = 8;
    localparam int AVG_W   = 7;
    localparam int ACT_W   = 8;
    localparam int CAP_W   = 16;
    localparam int BLINK_W = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [FREQ_W-1:0] FREQ_MIN_RST = FREQ_W'(500);
    localparam logic [FREQ_W-1:0] FREQ_MAX_RST = FREQ_W'(20000);
    localparam logic [ACT_W-1:0]  ACT_RELOAD_RST = ACT_W'(15);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FREQ_MIN   = 2'd0,
        REG_FREQ_MAX   = 2'd1,
        REG_ACT_RELOAD = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [FREQ_W-1:0] meas_freq;
        logic [DUTY_W-1:0] meas_duty;
        logic              dir_level;
        logic              ctl_level;
        logic [CAP_W-1:0]  capture_val;
    } in_item_t;

    typedef struct packed {
        logic signed [7:0] speed_cmd;
        logic [AVG_W-1:0]  mean_duty;
        logic              led_level;
        logic [ACT_W-1:0]  activity_left;
    } out_item_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_min;
        logic [FREQ_W-1:0] freq_max;
        logic [ACT_W-1:0]  activity_reload;
    } cfg_t;

    typedef struct packed {
        logic [AVG_W-1:0] duty;
        logic [POS_W-1:0] pos;
        logic             dir;
        logic [ACT_W-1:0] act;
    } s1_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               dir;
        logic [ACT_W-1:0]   act;
    } s2_t;

endpackage
`default_nettype wire

/* src/pcms_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module pcms_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire pcms_pkg::in_item_t in_item,
    input  wire pcms_pkg::cfg_t     cfg,
    output pcms_pkg::s1_t           s1_item
);
    import pcms_pkg::*;

    logic [ACT_W-1:0] act_reg, act_next;
    logic             prev_ctl_reg;
    logic [CAP_W-1:0] prev_cap_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [AVG_W-1:0] duty_sat;
    logic             in_window;

    always_comb begin
        duty_sat = (in_item.meas_duty > DUTY_W'(DUTY_MAX)) ? AVG_W'(DUTY_MAX)
                                                           : in_item.meas_duty[AVG_W-1:0];
        in_window = (in_item.meas_freq >= cfg.freq_min) &&
                    (in_item.meas_freq <= cfg.freq_max);

        if ((in_item.ctl_level != prev_ctl_reg) || (in_item.capture_val != prev_cap_reg)) begin
            act_next = cfg.activity_reload;
        end else if (act_reg != '0) begin
            act_next = act_reg - ACT_W'(1);
        end else begin
            act_next = '0;
        end

        if (pos_reg == POS_W'(HISTORY_DEPTH - 1)) begin
            pos_next = '0;
        end else begin
            pos_next = pos_reg + POS_W'(1);
        end

        // The qualification uses the countdown left by the previous item.
        s1_item.duty = (in_window && (act_reg != '0)) ? duty_sat : '0;
        s1_item.pos  = pos_reg;
        s1_item.dir  = in_item.dir_level;
        s1_item.act  = act_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg      <= '0;
            prev_ctl_reg <= 1'b0;
            prev_cap_reg <= '0;
            pos_reg      <= '0;
        end else if (accept) begin
            act_reg      <= act_next;
            prev_ctl_reg <= in_item.ctl_level;
            prev_cap_reg <= in_item.capture_val;
            pos_reg      <= pos_next;
        end
    end

endmodule
`default_nettype wire

/* src/pcms_hist.sv */
`timescale 1ns / 1ps
`default_nettype none
module pcms_hist (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          accept,
    input  wire pcms_pkg::s1_t s1_in,
    input  wire logic          out_en,
    output logic               in_ready,
    output logic               s2_valid,
    output pcms_pkg::s2_t      s2_item
);
    import pcms_pkg::*;

    logic [AVG_W-1:0]         hist_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] vld_reg;
    logic [AVG_W-1:0]         rd_reg;
    logic                     rvld_reg;
    logic                     fwd_reg;
    logic [AVG_W-1:0]         fwd_data_reg;
    s1_t                      s1_reg;
    logic                     s1_valid_reg, s1_valid_next;
    s2_t                      s2_reg;
    logic                     s2_valid_reg, s2_valid_next;
    logic [TOTAL_W-1:0]       total_reg, total_next;
    logic [AVG_W-1:0]         old_duty;
    logic                     s2_en, s1_go;

    always_comb begin
        s2_en    = !s2_valid_reg || out_en;
        s1_go    = s1_valid_reg && s2_en;
        in_ready = !s1_valid_reg || s2_en;

        // Entries never written since reset read as zero.
        if (fwd_reg) begin
            old_duty = fwd_data_reg;
        end else if (rvld_reg) begin
            old_duty = rd_reg;
        end else begin
            old_duty = '0;
        end
        total_next = total_reg - TOTAL_W'(old_duty) + TOTAL_W'(s1_reg.duty);

        s1_valid_next = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        s2_valid_next = s1_go ? 1'b1 : ((s2_valid_reg && out_en) ? 1'b0 : s2_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            hist_mem[s1_reg.pos] <= s1_reg.duty;
        end
        if (accept) begin
            rd_reg       <= hist_mem[s1_in.pos];
            rvld_reg     <= vld_reg[s1_in.pos];
            // The entry being written this cycle is read stale; keep its new value.
            fwd_reg      <= s1_go && (s1_reg.pos == s1_in.pos);
            fwd_data_reg <= s1_reg.duty;
            s1_reg       <= s1_in;
        end
        if (s1_go) begin
            s2_reg.total <= total_next;
            s2_reg.dir   <= s1_reg.dir;
            s2_reg.act   <= s1_reg.act;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            total_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_go) begin
                vld_reg[s1_reg.pos] <= 1'b1;
                total_reg           <= total_next;
            end
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_item  = s2_reg;

endmodule
`default_nettype wire

/* src/pcms_out.sv */
`timescale 1ns / 1ps
`default_nettype none
module pcms_out (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s2_valid,
    input  wire pcms_pkg::s2_t s2_item,
    output logic               out_en,
    output logic               m_valid,
    input  wire logic          m_ready,
    output pcms_pkg::out_item_t m_data
);
    import pcms_pkg::*;

    localparam logic [TOTAL_W:0] RECIP = (TOTAL_W + 1)'(DIV_M);

    logic [2*TOTAL_W:0]   prod;
    logic [TOTAL_W-1:0]   quo;
    logic [AVG_W-1:0]     avg;
    logic [BLINK_W-1:0]   period;
    logic [BLINK_W-1:0]   half;
    logic [BLINK_W:0]     blink_inc;
    logic                 led;
    logic signed [7:0]    speed;
    logic [BLINK_W-1:0]   blink_reg, blink_next;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_data_reg;
    logic                 load;

    always_comb begin
        out_en = !m_valid_reg || m_ready;
        load   = s2_valid && out_en;

        prod = (2*TOTAL_W+1)'(s2_item.total) * (2*TOTAL_W+1)'(RECIP);
        quo  = TOTAL_W'(prod >> (TOTAL_W + DIV_L));
        avg  = (quo > TOTAL_W'(DUTY_MAX)) ? AVG_W'(DUTY_MAX) : quo[AVG_W-1:0];

        speed = s2_item.dir ? $signed({1'b0, avg}) : -$signed({1'b0, avg});

        // Blink period shortens as the speed magnitude grows.
        period    = BLINK_W'((AVG_W'(DUTY_MAX) - avg) >> 1) + BLINK_W'(PERIOD_BASE);
        half      = period >> 1;
        led       = (blink_reg < half) ? 1'b0 : 1'b1;
        blink_inc = {1'b0, blink_reg} + (BLINK_W+1)'(1);
        blink_next = (blink_inc > {1'b0, period}) ? '0 : blink_inc[BLINK_W-1:0];

        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg.speed_cmd     <= speed;
            m_data_reg.mean_duty     <= avg;
            m_data_reg.led_level     <= led;
            m_data_reg.activity_left <= s2_item.act;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                blink_reg <= blink_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

/* src/pwm_command_to_motor_speed_top.sv */
// Path: an accepted item is held in s1_reg, then s2_reg, then m_data_reg, which drives m_data.
// Throughput: one item per cycle while m_ready stays high; the duty history memory is read
// at acceptance and written back as the item leaves s1_reg, with forwarding on the same entry.
// Reset: aresetn is synchronous and active low; it restores the register defaults, clears
// the running sum, counters and the per-entry valid bits, so history entries read as zero.
`timescale 1ns / 1ps
`default_nettype none
module pwm_command_to_motor_speed_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire pcms_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output pcms_pkg::out_item_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [19:0]         cfg_data
);
    import pcms_pkg::*;

    cfg_t  cfg_reg;
    s1_t   s1_item;
    s2_t   s2_item;
    logic  s2_valid;
    logic  out_en;
    logic  in_ready;
    logic  accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = in_ready;
    assign accept    = s_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.freq_min        <= FREQ_MIN_RST;
            cfg_reg.freq_max        <= FREQ_MAX_RST;
            cfg_reg.activity_reload <= ACT_RELOAD_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FREQ_MIN:   cfg_reg.freq_min        <= cfg_data;
                REG_FREQ_MAX:   cfg_reg.freq_max        <= cfg_data;
                REG_ACT_RELOAD: cfg_reg.activity_reload <= cfg_data[ACT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pcms_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_item (s_data),
        .cfg     (cfg_reg),
        .s1_item (s1_item)
    );

    pcms_hist u_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .s1_in    (s1_item),
        .out_en   (out_en),
        .in_ready (in_ready),
        .s2_valid (s2_valid),
        .s2_item  (s2_item)
    );

    pcms_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s2_valid (s2_valid),
        .s2_item  (s2_item),
        .out_en   (out_en),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

/* src/pcms_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module pcms_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire pcms_pkg::out_item_t m_data,
    input wire logic                cfg_valid,
    input wire logic                cfg_ready
);
    import pcms_pkg::*;

    logic signed [7:0] avg_s;
    assign avg_s = $signed({1'b0, m_data.mean_duty});

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_avg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.mean_duty <= AVG_W'(DUTY_MAX))
        else $error("average duty above full scale");

    a_speed_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.speed_cmd == avg_s) || (m_data.speed_cmd == -avg_s))
        else $error("speed magnitude differs from average duty");

    a_cfg_always_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind pwm_command_to_motor_speed_top pcms_checker u_pcms_checker (.*);
`default_nettype wire
